[hdl/assert_macros.svh]
// assertion helpers, clocked on the rising edge, off while reset is held
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge
`define CHK_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("check failed");

// consequent must hold at the next edge after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

[hdl/sts_pkg.sv]
`default_nettype none
package sts_pkg;

    localparam int unsigned QueueDepth = 2;
    localparam int unsigned SqrtSteps  = 31;
    localparam int unsigned DivSteps   = 17;
    localparam logic [1:0]  LastIdx    = 2'd3;

    typedef struct packed {
        logic signed [15:0] c0_x;
        logic signed [15:0] c0_y;
        logic signed [15:0] c0_z;
        logic signed [15:0] c1_x;
        logic signed [15:0] c1_y;
        logic signed [15:0] c1_z;
        logic signed [15:0] c2_x;
        logic signed [15:0] c2_y;
        logic signed [15:0] c2_z;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] o0_x;
        logic signed [15:0] o0_y;
        logic signed [15:0] o0_z;
        logic signed [15:0] o1_x;
        logic signed [15:0] o1_y;
        logic signed [15:0] o1_z;
        logic signed [15:0] o2_x;
        logic signed [15:0] o2_y;
        logic signed [15:0] o2_z;
        logic               last_of_four;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic signed [16:0] z;
    } sum_vec_t;

    // one classified triangle: corners, edge sums and squared lengths
    typedef struct packed {
        in_item_t    corners;
        sum_vec_t    s_a;   // c0 + c2
        sum_vec_t    s_b;   // c0 + c1
        sum_vec_t    s_c;   // c1 + c2
        logic [33:0] l2_a;
        logic [33:0] l2_b;
        logic [33:0] l2_c;
    } work_t;

    typedef enum logic [2:0] {
        MID_IDLE,
        MID_SQRT,
        MID_PREP,
        MID_DIV,
        MID_DONE
    } mid_state_t;

endpackage
`default_nettype wire

[hdl/sts_front.sv]
`default_nettype none
module sts_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sts_pkg::in_item_t triangle,
    input  wire logic              push,
    output logic                   full,
    output sts_pkg::work_t         wdata,
    output logic                   wpush,
    input  wire logic              qfull
);

    logic              valid_reg, valid_next;
    sts_pkg::in_item_t tri_reg;
    sts_pkg::sum_vec_t sa_reg, sb_reg, sc_reg;
    logic              accept;

    function automatic logic [33:0] len2(input sts_pkg::sum_vec_t s);
        logic signed [33:0] px, py, pz;
        px = s.x * s.x;
        py = s.y * s.y;
        pz = s.z * s.z;
        return 34'(px) + 34'(py) + 34'(pz);
    endfunction

    assign wpush  = valid_reg && !qfull;
    assign full   = valid_reg && qfull;
    assign accept = push && !full;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (wpush)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tri_reg   <= triangle;
            sa_reg.x  <= 17'(triangle.c0_x) + 17'(triangle.c2_x);
            sa_reg.y  <= 17'(triangle.c0_y) + 17'(triangle.c2_y);
            sa_reg.z  <= 17'(triangle.c0_z) + 17'(triangle.c2_z);
            sb_reg.x  <= 17'(triangle.c0_x) + 17'(triangle.c1_x);
            sb_reg.y  <= 17'(triangle.c0_y) + 17'(triangle.c1_y);
            sb_reg.z  <= 17'(triangle.c0_z) + 17'(triangle.c1_z);
            sc_reg.x  <= 17'(triangle.c1_x) + 17'(triangle.c2_x);
            sc_reg.y  <= 17'(triangle.c1_y) + 17'(triangle.c2_y);
            sc_reg.z  <= 17'(triangle.c1_z) + 17'(triangle.c2_z);
        end
    end

    always_comb
    begin
        wdata.corners = tri_reg;
        wdata.s_a     = sa_reg;
        wdata.s_b     = sb_reg;
        wdata.s_c     = sc_reg;
        wdata.l2_a    = len2(sa_reg);
        wdata.l2_b    = len2(sb_reg);
        wdata.l2_c    = len2(sc_reg);
    end

endmodule
`default_nettype wire

[hdl/sts_queue.sv]
`default_nettype none
`include "assert_macros.svh"
// small FIFO; DEPTH is a power of two, 2 or more
module sts_queue #(
    parameter int unsigned DEPTH = sts_pkg::QueueDepth
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sts_pkg::work_t wdata,
    input  wire logic           wpush,
    output logic                qfull,
    output sts_pkg::work_t      rdata,
    input  wire logic           rpop,
    output logic                qempty
);

    localparam int unsigned PtrW = $clog2(DEPTH);
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    sts_pkg::work_t  mem [DEPTH];
    logic [PtrW-1:0] wptr_reg, rptr_reg;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_w, do_r;

    assign qfull  = (cnt_reg == CntW'(DEPTH));
    assign qempty = (cnt_reg == '0);
    assign do_w   = wpush && !qfull;
    assign do_r   = rpop && !qempty;
    assign rdata  = mem[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_w && !do_r)
            cnt_next = cnt_reg + 1'b1;
        else if (do_r && !do_w)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_w)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_r)
                rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_w)
            mem[wptr_reg] <= wdata;
    end

    `CHK_ALWAYS(a_cnt_bound, clk, rst_n, cnt_reg <= CntW'(DEPTH))
    `CHK_NEXT(a_ptr_gap, clk, rst_n, qempty && !do_w, wptr_reg == rptr_reg)

endmodule
`default_nettype wire

[hdl/sts_mid.sv]
`default_nettype none
// one edge midpoint: bit-serial root, then three restoring dividers
module sts_mid (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire sts_pkg::sum_vec_t s,
    input  wire logic [33:0]       l2,
    input  wire logic              ack,
    output logic                   done,
    output sts_pkg::vec_t          res
);

    sts_pkg::mid_state_t st_reg, st_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [61:0]         rad_reg;
    logic [32:0]         rem_reg;
    logic [30:0]         root_reg;
    logic                zero_reg;
    logic [2:0]          sgn_reg;
    logic [2:0][16:0]    mag_reg;
    logic [31:0]         d_reg;
    logic [2:0][31:0]    drem_reg;
    logic [2:0][16:0]    dlo_reg;
    logic [2:0][16:0]    q_reg;
    logic [2:0][16:0]    s_arr;
    logic [34:0]         sq_t, sq_trial;
    logic                sq_take;
    logic [2:0][15:0]    r_arr;

    assign s_arr   = {s.x, s.y, s.z};
    assign sq_t    = {rem_reg, rad_reg[61:60]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_take = (sq_t >= sq_trial);
    assign done    = (st_reg == sts_pkg::MID_DONE);

    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        unique case (st_reg)
            sts_pkg::MID_IDLE:
            begin
                cnt_next = '0;
                if (start)
                    st_next = sts_pkg::MID_SQRT;
            end
            sts_pkg::MID_SQRT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(sts_pkg::SqrtSteps - 1))
                    st_next = sts_pkg::MID_PREP;
            end
            sts_pkg::MID_PREP:
            begin
                cnt_next = '0;
                st_next  = sts_pkg::MID_DIV;
            end
            sts_pkg::MID_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(sts_pkg::DivSteps - 1))
                    st_next = sts_pkg::MID_DONE;
            end
            sts_pkg::MID_DONE:
            begin
                if (ack)
                    st_next = sts_pkg::MID_IDLE;
            end
            default:
                st_next = sts_pkg::MID_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= sts_pkg::MID_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [45:0] dvd;
        logic [32:0] t;
        if (st_reg == sts_pkg::MID_IDLE && start)
        begin
            rad_reg  <= {l2, 28'b0};
            rem_reg  <= '0;
            root_reg <= '0;
            zero_reg <= (l2 == '0);
            for (int i = 0; i < 3; i++)
            begin
                sgn_reg[i] <= s_arr[i][16];
                mag_reg[i] <= s_arr[i][16] ? 17'(-s_arr[i]) : s_arr[i];
            end
        end
        else if (st_reg == sts_pkg::MID_SQRT)
        begin
            rad_reg <= {rad_reg[59:0], 2'b00};
            if (sq_take)
            begin
                rem_reg  <= 33'(sq_t - sq_trial);
                root_reg <= {root_reg[29:0], 1'b1};
            end
            else
            begin
                rem_reg  <= sq_t[32:0];
                root_reg <= {root_reg[29:0], 1'b0};
            end
        end
        else if (st_reg == sts_pkg::MID_PREP)
        begin
            d_reg <= {root_reg, 1'b0};
            for (int i = 0; i < 3; i++)
            begin
                dvd = {mag_reg[i], 29'b0} + {15'b0, root_reg};
                drem_reg[i] <= {3'b000, dvd[45:17]};
                dlo_reg[i]  <= dvd[16:0];
                q_reg[i]    <= '0;
            end
        end
        else if (st_reg == sts_pkg::MID_DIV)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t = {drem_reg[i], dlo_reg[i][16]};
                dlo_reg[i] <= {dlo_reg[i][15:0], 1'b0};
                if (t >= {1'b0, d_reg})
                begin
                    drem_reg[i] <= 32'(t - {1'b0, d_reg});
                    q_reg[i]    <= {q_reg[i][15:0], 1'b1};
                end
                else
                begin
                    drem_reg[i] <= t[31:0];
                    q_reg[i]    <= {q_reg[i][15:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (zero_reg)
                r_arr[i] = '0;
            else if (sgn_reg[i])
                r_arr[i] = 16'(-q_reg[i][15:0]);
            else
                r_arr[i] = q_reg[i][15:0];
        end
        res.x = r_arr[2];
        res.y = r_arr[1];
        res.z = r_arr[0];
    end

endmodule
`default_nettype wire

[hdl/sts_back.sv]
`default_nettype none
`include "assert_macros.svh"
module sts_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sts_pkg::work_t rdata,
    input  wire logic           qempty,
    output logic                rpop,
    output sts_pkg::out_item_t  subtri,
    output logic                empty,
    input  wire logic           pop
);

    logic              busy_reg;
    sts_pkg::in_item_t cur_reg;
    logic [2:0]        mdone;
    sts_pkg::vec_t     ma, mb, mc;
    logic              done_all, load, emit_last, start;

    logic              ev_reg;
    logic [1:0]        idx_reg;
    sts_pkg::vec_t     c0_reg, c1_reg, c2_reg, a_reg, b_reg, m_reg;
    sts_pkg::vec_t     p0, p1, p2;

    assign start     = !busy_reg && !qempty;
    assign rpop      = start;
    assign done_all  = &mdone;
    assign emit_last = ev_reg && pop && (idx_reg == sts_pkg::LastIdx);
    assign load      = busy_reg && done_all && (!ev_reg || emit_last);
    assign empty     = !ev_reg;

    sts_mid u_mid_a (
        .clk(clk), .rst_n(rst_n), .start(start), .s(rdata.s_a), .l2(rdata.l2_a),
        .ack(load), .done(mdone[0]), .res(ma)
    );
    sts_mid u_mid_b (
        .clk(clk), .rst_n(rst_n), .start(start), .s(rdata.s_b), .l2(rdata.l2_b),
        .ack(load), .done(mdone[1]), .res(mb)
    );
    sts_mid u_mid_c (
        .clk(clk), .rst_n(rst_n), .start(start), .s(rdata.s_c), .l2(rdata.l2_c),
        .ack(load), .done(mdone[2]), .res(mc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ev_reg   <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            if (start)
                busy_reg <= 1'b1;
            else if (load)
                busy_reg <= 1'b0;
            if (load)
            begin
                ev_reg  <= 1'b1;
                idx_reg <= '0;
            end
            else if (ev_reg && pop)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == sts_pkg::LastIdx)
                    ev_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            cur_reg <= rdata.corners;
        if (load)
        begin
            c0_reg <= {cur_reg.c0_x, cur_reg.c0_y, cur_reg.c0_z};
            c1_reg <= {cur_reg.c1_x, cur_reg.c1_y, cur_reg.c1_z};
            c2_reg <= {cur_reg.c2_x, cur_reg.c2_y, cur_reg.c2_z};
            a_reg  <= ma;
            b_reg  <= mb;
            m_reg  <= mc;
        end
    end

    // sub-triangle order: (c0,b,a) (b,c1,m) (a,b,m) (a,m,c2)
    always_comb
    begin
        case (idx_reg)
            2'd0:
            begin
                p0 = c0_reg; p1 = b_reg; p2 = a_reg;
            end
            2'd1:
            begin
                p0 = b_reg; p1 = c1_reg; p2 = m_reg;
            end
            2'd2:
            begin
                p0 = a_reg; p1 = b_reg; p2 = m_reg;
            end
            default:
            begin
                p0 = a_reg; p1 = m_reg; p2 = c2_reg;
            end
        endcase
        subtri.o0_x = p0.x; subtri.o0_y = p0.y; subtri.o0_z = p0.z;
        subtri.o1_x = p1.x; subtri.o1_y = p1.y; subtri.o1_z = p1.z;
        subtri.o2_x = p2.x; subtri.o2_y = p2.y; subtri.o2_z = p2.z;
        subtri.last_of_four = (idx_reg == sts_pkg::LastIdx);
    end

    `CHK_ALWAYS(a_lockstep, clk, rst_n, (mdone[0] == mdone[1]) && (mdone[1] == mdone[2]))
    `CHK_ALWAYS(a_idle_units, clk, rst_n, busy_reg || !(|mdone))
    `CHK_NEXT(a_last_drains, clk, rst_n, emit_last && !load, empty)

endmodule
`default_nettype wire

[hdl/sphere_triangle_subdivider_top.sv]
// An accepted triangle passes the front register and the queue, then the three
// midpoint lanes, before its first sub-triangle is shown (empty low).
// Each midpoint lane runs start, the 31-step serial root, a divider setup state,
// the 17-step dividers and handoff; it takes a new triangle only after handoff.
// The four sub-triangles leave on consecutive cycles when pop is held high.
// Reset (rst_n low, asynchronous) empties the queue and drops any work.
`default_nettype none
module sphere_triangle_subdivider_top #(
    parameter int unsigned QUEUE_DEPTH = sts_pkg::QueueDepth
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sts_pkg::in_item_t  triangle,
    input  wire logic               push,
    output logic                    full,
    output sts_pkg::out_item_t      subtri,
    output logic                    empty,
    input  wire logic               pop
);

    // front: registers the item, forms edge sums and squared lengths
    sts_pkg::work_t wdata, rdata;
    logic           wpush, qfull, rpop, qempty;

    sts_front u_front (
        .clk(clk), .rst_n(rst_n), .triangle(triangle), .push(push), .full(full),
        .wdata(wdata), .wpush(wpush), .qfull(qfull)
    );

    // short queue of classified items between front and back
    sts_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .wdata(wdata), .wpush(wpush), .qfull(qfull),
        .rdata(rdata), .rpop(rpop), .qempty(qempty)
    );

    // back: three midpoint lanes (root then divide) and the emit buffer;
    // the buffer holds a finished item while the lanes start the next one
    sts_back u_back (
        .clk(clk), .rst_n(rst_n), .rdata(rdata), .qempty(qempty), .rpop(rpop),
        .subtri(subtri), .empty(empty), .pop(pop)
    );

endmodule
`default_nettype wire
